FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent true implies consequent true in the same cycle.
`define ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Antecedent true implies consequent true in the next cycle.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: rtl/alex_pkg.sv
// Shared types, constants and character decode for the expression lexer.
`timescale 1ns / 1ps
package alex_pkg;

    localparam int MAGNITUDE_BITS_DEF = 32;
    localparam int LENGTH_BITS_DEF    = 8;
    localparam int QUEUE_DEPTH_DEF    = 4;

    localparam logic [7:0] CHAR_PLUS   = 8'h2B;
    localparam logic [7:0] CHAR_MINUS  = 8'h2D;
    localparam logic [7:0] CHAR_TIMES  = 8'h2A;
    localparam logic [7:0] CHAR_DIVIDE = 8'h2F;
    localparam logic [7:0] CHAR_LPAREN = 8'h28;
    localparam logic [7:0] CHAR_RPAREN = 8'h29;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;

    typedef enum logic [2:0] {
        KIND_NUMBER   = 3'd0,
        KIND_OPERATOR = 3'd1,
        KIND_LPAREN   = 3'd2,
        KIND_RPAREN   = 3'd3,
        KIND_UNKNOWN  = 3'd4,
        KIND_END      = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        OP_PLUS   = 2'd0,
        OP_MINUS  = 2'd1,
        OP_TIMES  = 2'd2,
        OP_DIVIDE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_NUMBER  = 2'd1,
        MODE_MINUS   = 2'd2,
        MODE_UNKNOWN = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        CLS_DIGIT,
        CLS_SPACE,
        CLS_OP,
        CLS_MINUS,
        CLS_LPAREN,
        CLS_RPAREN,
        CLS_UNKNOWN
    } cls_t;

    typedef struct packed {
        kind_t kind;
        op_t   op;
        logic  neg;
        logic  ovf;
    } tok_t;

    // One queue entry: up to two tokens from one request.
    typedef struct packed {
        logic two;
        tok_t t0;
        tok_t t1;
    } head_t;

    function automatic cls_t classify(input logic [7:0] c);
        cls_t r;
        if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
            r = CLS_DIGIT;
        end else if (c == CHAR_SPACE || c inside {[CHAR_TAB:CHAR_CR]}) begin
            r = CLS_SPACE;
        end else if (c == CHAR_MINUS) begin
            r = CLS_MINUS;
        end else if (c inside {CHAR_PLUS, CHAR_TIMES, CHAR_DIVIDE}) begin
            r = CLS_OP;
        end else if (c == CHAR_LPAREN) begin
            r = CLS_LPAREN;
        end else if (c == CHAR_RPAREN) begin
            r = CLS_RPAREN;
        end else begin
            r = CLS_UNKNOWN;
        end
        return r;
    endfunction

    function automatic op_t op_of(input logic [7:0] c);
        op_t r;
        case (c)
            CHAR_PLUS:   r = OP_PLUS;
            CHAR_MINUS:  r = OP_MINUS;
            CHAR_TIMES:  r = OP_TIMES;
            default:     r = OP_DIVIDE;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/arithmetic_expression_lexer.sv
// Arithmetic expression lexer: one character per request in, tokens out.
// Takes one character request per cycle while the token queue has room. A
// request that ends a pending token and also yields a token of its own (an
// operator or parenthesis, or the end request, after a pending token)
// produces two tokens, which the output register sends one per cycle while
// m_ready is high; the QUEUE_DEPTH-entry queue absorbs short bursts of them.
// With an empty queue and a free output, a token passes through a queue slot
// and then the output register. A lone '-' is held until the next character
// or end request decides whether it starts a negative number.
`timescale 1ns / 1ps
module arithmetic_expression_lexer #(
    parameter int MAGNITUDE_BITS = alex_pkg::MAGNITUDE_BITS_DEF,
    parameter int LENGTH_BITS    = alex_pkg::LENGTH_BITS_DEF,
    parameter int QUEUE_DEPTH    = alex_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_command,
    input  logic [7:0]                s_char_code,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [2:0]                m_token_kind,
    output logic [1:0]                m_operator_code,
    output logic [MAGNITUDE_BITS-1:0] m_magnitude,
    output logic                      m_is_negative,
    output logic [LENGTH_BITS-1:0]    m_token_length,
    output logic                      m_overflowed,
    output logic                      m_last_of_run
);
    import alex_pkg::*;

    localparam int HEAD_W  = $bits(head_t);
    localparam int ENTRY_W = HEAD_W + MAGNITUDE_BITS + LENGTH_BITS;

    logic                      queue_full, queue_empty, push, pop;
    head_t                     wr_head, rd_head;
    logic [MAGNITUDE_BITS-1:0] wr_mag, rd_mag;
    logic [LENGTH_BITS-1:0]    wr_len, rd_len;
    logic [ENTRY_W-1:0]        wr_entry, rd_entry;

    alex_front #(
        .MAGNITUDE_BITS(MAGNITUDE_BITS),
        .LENGTH_BITS   (LENGTH_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item_valid(s_valid),
        .queue_full(queue_full),
        .command   (s_command),
        .char_code (s_char_code),
        .item_ready(s_ready),
        .push      (push),
        .head      (wr_head),
        .mag       (wr_mag),
        .len       (wr_len)
    );

    assign wr_entry = {wr_head, wr_mag, wr_len};

    alex_fifo #(
        .WIDTH(ENTRY_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push   (push),
        .wdata  (wr_entry),
        .full   (queue_full),
        .pop    (pop),
        .rdata  (rd_entry),
        .empty  (queue_empty)
    );

    assign rd_head = rd_entry[ENTRY_W-1 -: HEAD_W];
    assign rd_mag  = rd_entry[LENGTH_BITS +: MAGNITUDE_BITS];
    assign rd_len  = rd_entry[LENGTH_BITS-1:0];

    alex_back #(
        .MAGNITUDE_BITS(MAGNITUDE_BITS),
        .LENGTH_BITS   (LENGTH_BITS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .empty          (queue_empty),
        .head           (rd_head),
        .mag            (rd_mag),
        .len            (rd_len),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_token_kind   (m_token_kind),
        .m_operator_code(m_operator_code),
        .m_magnitude    (m_magnitude),
        .m_is_negative  (m_is_negative),
        .m_token_length (m_token_length),
        .m_overflowed   (m_overflowed),
        .m_last_of_run  (m_last_of_run)
    );

endmodule

FILE: rtl/alex_front.sv
// Front end: character decode, scan state and token assembly.
`timescale 1ns / 1ps
module alex_front #(
    parameter int MAGNITUDE_BITS = alex_pkg::MAGNITUDE_BITS_DEF,
    parameter int LENGTH_BITS    = alex_pkg::LENGTH_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      item_valid,
    input  logic                      queue_full,
    input  logic                      command,
    input  logic [7:0]                char_code,
    output logic                      item_ready,
    output logic                      push,
    output alex_pkg::head_t           head,
    output logic [MAGNITUDE_BITS-1:0] mag,
    output logic [LENGTH_BITS-1:0]    len
);
    import alex_pkg::*;

    localparam logic [MAGNITUDE_BITS-1:0] MAG_MAX = '1;
    localparam logic [LENGTH_BITS-1:0]    LEN_MAX = '1;

    mode_t                     mode_reg, mode_next;
    logic [MAGNITUDE_BITS-1:0] acc_reg, acc_next;
    logic                      sign_reg, sign_next;
    logic [LENGTH_BITS-1:0]    cnt_reg, cnt_next;
    logic                      sat_reg, sat_next;

    cls_t                      cls;
    logic [3:0]                digit;
    logic                      accept;
    logic                      extend_num, neg_start, extend_unk, restart;
    logic [LENGTH_BITS-1:0]    cnt_inc;
    logic [MAGNITUDE_BITS+3:0] wide;
    logic                      digit_ovf;
    logic [MAGNITUDE_BITS-1:0] acc_digit;
    logic [MAGNITUDE_BITS-1:0] digit_ext;

    tok_t                      pend_tok, e2_tok;
    logic                      e1_valid, e2_valid;
    logic [LENGTH_BITS-1:0]    pend_len;
    logic [MAGNITUDE_BITS-1:0] pend_mag;

    assign cls        = classify(char_code);
    assign digit      = char_code[3:0];
    assign accept     = item_valid && !queue_full;
    assign item_ready = !queue_full;

    assign extend_num = !command && mode_reg == MODE_NUMBER && cls == CLS_DIGIT;
    assign neg_start  = !command && mode_reg == MODE_MINUS && cls == CLS_DIGIT;
    assign extend_unk = !command && mode_reg == MODE_UNKNOWN && cls == CLS_UNKNOWN;
    assign restart    = !command && !extend_num && !neg_start && !extend_unk;

    assign cnt_inc   = (cnt_reg == LEN_MAX) ? cnt_reg : cnt_reg + 1'b1;
    assign digit_ext = {{(MAGNITUDE_BITS-4){1'b0}}, digit};
    // acc * 10 + digit, four guard bits catch overflow
    assign wide = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                + {{MAGNITUDE_BITS{1'b0}}, digit};
    assign digit_ovf = wide[MAGNITUDE_BITS+3:MAGNITUDE_BITS] != 4'd0;
    assign acc_digit = digit_ovf ? MAG_MAX : wide[MAGNITUDE_BITS-1:0];

    // scan mode
    always_comb begin
        mode_next = mode_reg;
        if (accept) begin
            if (command) begin
                mode_next = MODE_IDLE;
            end else if (neg_start) begin
                mode_next = MODE_NUMBER;
            end else if (restart) begin
                case (cls)
                    CLS_DIGIT:   mode_next = MODE_NUMBER;
                    CLS_MINUS:   mode_next = MODE_MINUS;
                    CLS_UNKNOWN: mode_next = MODE_UNKNOWN;
                    default:     mode_next = MODE_IDLE;
                endcase
            end
        end
    end

    // accumulator, sign, count and saturation
    always_comb begin
        acc_next  = acc_reg;
        sign_next = sign_reg;
        cnt_next  = cnt_reg;
        sat_next  = sat_reg;
        if (accept) begin
            if (extend_num) begin
                cnt_next = cnt_inc;
                acc_next = acc_digit;
                sat_next = sat_reg | digit_ovf;
            end else if (neg_start) begin
                cnt_next  = LENGTH_BITS'(2);
                sign_next = 1'b1;
                acc_next  = digit_ext;
                sat_next  = 1'b0;
            end else if (extend_unk) begin
                cnt_next = cnt_inc;
            end else begin
                acc_next  = '0;
                sign_next = 1'b0;
                cnt_next  = '0;
                sat_next  = 1'b0;
                if (!command && cls == CLS_DIGIT) begin
                    cnt_next = LENGTH_BITS'(1);
                    acc_next = digit_ext;
                end else if (!command && cls == CLS_UNKNOWN) begin
                    cnt_next = LENGTH_BITS'(1);
                end
            end
        end
    end

    // token assembly
    always_comb begin
        pend_tok      = '{kind: KIND_NUMBER, op: OP_PLUS, neg: 1'b0, ovf: 1'b0};
        pend_len      = cnt_reg;
        pend_mag      = '0;
        case (mode_reg)
            MODE_NUMBER: begin
                pend_tok.neg = sign_reg;
                pend_tok.ovf = sat_reg;
                pend_mag     = acc_reg;
            end
            MODE_MINUS: begin
                pend_tok.kind = KIND_OPERATOR;
                pend_tok.op   = OP_MINUS;
                pend_len      = LENGTH_BITS'(1);
            end
            default: begin
                pend_tok.kind = KIND_UNKNOWN;
            end
        endcase

        e2_tok   = '{kind: KIND_END, op: OP_PLUS, neg: 1'b0, ovf: 1'b0};
        e2_valid = 1'b0;
        if (command) begin
            e2_valid = 1'b1;
        end else if (restart) begin
            case (cls)
                CLS_OP: begin
                    e2_valid    = 1'b1;
                    e2_tok.kind = KIND_OPERATOR;
                    e2_tok.op   = op_of(char_code);
                end
                CLS_LPAREN: begin
                    e2_valid    = 1'b1;
                    e2_tok.kind = KIND_LPAREN;
                end
                CLS_RPAREN: begin
                    e2_valid    = 1'b1;
                    e2_tok.kind = KIND_RPAREN;
                end
                default: e2_valid = 1'b0;
            endcase
        end
        e1_valid = (command || restart) && mode_reg != MODE_IDLE;

        push     = accept && (e1_valid || e2_valid);
        head.two = e1_valid && e2_valid;
        head.t0  = e1_valid ? pend_tok : e2_tok;
        head.t1  = e2_tok;
        mag      = e1_valid ? pend_mag : '0;
        if (e1_valid) begin
            len = pend_len;
        end else if (e2_tok.kind == KIND_END) begin
            len = '0;
        end else begin
            len = LENGTH_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            acc_reg  <= '0;
            sign_reg <= 1'b0;
            cnt_reg  <= '0;
            sat_reg  <= 1'b0;
        end else begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            sign_reg <= sign_next;
            cnt_reg  <= cnt_next;
            sat_reg  <= sat_next;
        end
    end

endmodule

FILE: rtl/alex_fifo.sv
// Short token queue between front and back end.
`timescale 1ns / 1ps
module alex_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = alex_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = count_reg == (PTR_W+1)'(DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_reg];

    always_comb begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        count_next = count_reg;
        if (do_push) begin
            wr_next = (wr_reg == LAST_SLOT) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_next = (rd_reg == LAST_SLOT) ? '0 : rd_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

endmodule

FILE: rtl/alex_back.sv
// Back end: splits queue entries into single tokens behind an output register.
`timescale 1ns / 1ps
module alex_back #(
    parameter int MAGNITUDE_BITS = alex_pkg::MAGNITUDE_BITS_DEF,
    parameter int LENGTH_BITS    = alex_pkg::LENGTH_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      empty,
    input  alex_pkg::head_t           head,
    input  logic [MAGNITUDE_BITS-1:0] mag,
    input  logic [LENGTH_BITS-1:0]    len,
    output logic                      pop,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [2:0]                m_token_kind,
    output logic [1:0]                m_operator_code,
    output logic [MAGNITUDE_BITS-1:0] m_magnitude,
    output logic                      m_is_negative,
    output logic [LENGTH_BITS-1:0]    m_token_length,
    output logic                      m_overflowed,
    output logic                      m_last_of_run
);
    import alex_pkg::*;

    logic                      valid_reg, valid_next;
    logic                      phase_reg, phase_next;
    tok_t                      tok_reg, tok_sel;
    logic [MAGNITUDE_BITS-1:0] mag_reg;
    logic [LENGTH_BITS-1:0]    len_reg, len_sel;
    logic                      last_reg;
    logic                      load;

    assign load    = !valid_reg || m_ready;
    assign tok_sel = phase_reg ? head.t1 : head.t0;
    assign pop     = load && !empty && (!head.two || phase_reg);

    always_comb begin
        if (!phase_reg) begin
            len_sel = len;
        end else if (head.t1.kind == KIND_END) begin
            len_sel = '0;
        end else begin
            len_sel = LENGTH_BITS'(1);
        end
    end

    always_comb begin
        valid_next = valid_reg;
        phase_next = phase_reg;
        if (load) begin
            valid_next = !empty;
            if (!empty) begin
                phase_next = head.two && !phase_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && !empty) begin
            tok_reg  <= tok_sel;
            mag_reg  <= phase_reg ? '0 : mag;
            len_reg  <= len_sel;
            last_reg <= !head.two || phase_reg;
        end
    end

    assign m_valid         = valid_reg;
    assign m_token_kind    = tok_reg.kind;
    assign m_operator_code = tok_reg.op;
    assign m_magnitude     = mag_reg;
    assign m_is_negative   = tok_reg.neg;
    assign m_token_length  = len_reg;
    assign m_overflowed    = tok_reg.ovf;
    assign m_last_of_run   = last_reg;

endmodule

FILE: rtl/alex_checker.sv
// Port-level checks on token output, bound to the lexer top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module alex_checker #(
    parameter int MAGNITUDE_BITS = alex_pkg::MAGNITUDE_BITS_DEF,
    parameter int LENGTH_BITS    = alex_pkg::LENGTH_BITS_DEF
) (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic [2:0]                m_token_kind,
    input logic [1:0]                m_operator_code,
    input logic [MAGNITUDE_BITS-1:0] m_magnitude,
    input logic                      m_is_negative,
    input logic [LENGTH_BITS-1:0]    m_token_length,
    input logic                      m_overflowed,
    input logic                      m_last_of_run
);
    import alex_pkg::*;

    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_token_kind) && $stable(m_magnitude) && $stable(m_token_length))
    `ASSERT_SAME(a_non_number_clean, aclk, aresetn, m_valid && m_token_kind != KIND_NUMBER,
        m_magnitude == '0 && !m_is_negative && !m_overflowed)
    `ASSERT_SAME(a_end_token, aclk, aresetn, m_valid && m_token_kind == KIND_END,
        m_last_of_run && m_token_length == '0 && m_operator_code == OP_PLUS)
    `ASSERT_SAME(a_single_char, aclk, aresetn,
        m_valid && (m_token_kind == KIND_OPERATOR || m_token_kind == KIND_LPAREN
                    || m_token_kind == KIND_RPAREN),
        m_token_length == LENGTH_BITS'(1))

endmodule

bind arithmetic_expression_lexer alex_checker #(
    .MAGNITUDE_BITS(MAGNITUDE_BITS),
    .LENGTH_BITS   (LENGTH_BITS)
) u_alex_checker (.*);
